// ----- src/hgbs_pkg.sv -----
// shared types and constants for the height grid sampler
`timescale 1ns / 1ps
package hgbs_pkg;
  localparam int MaxCells = 65536;
  localparam int MaxSide = 1024;
  localparam int CfgW = 33;
  localparam int CfgIdxW = 3;
  localparam logic signed [35:0] FullTurn = 36'sd6039797760;
  localparam logic signed [35:0] HalfTurn = 36'sd3019898880;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_LAT = 3'd0, REG_ORIGIN_LON = 3'd1, REG_LAT_SCALE = 3'd2,
    REG_LON_SCALE = 3'd3, REG_COLUMNS = 3'd4, REG_ROWS = 3'd5,
    REG_MISS_CODE = 3'd6, REG_MISS_FILL = 3'd7
  } reg_idx_t;

  // one command handed from the front to the back
  typedef struct packed {
    logic        is_load;
    logic        loaded;
    logic signed [32:0] lat;
    logic signed [32:0] lon;
    logic signed [15:0] data;
  } query_t;

  // wrap a signed offset (range two turns wide) into [-180,180)
  function automatic logic signed [35:0] wrap_deg(input logic signed [35:0] d);
    logic signed [35:0] r;
    begin
      r = d;
      if (r >= HalfTurn) r = r - FullTurn;
      else if (r < -HalfTurn) r = r + FullTurn;
      if (r >= HalfTurn) r = r - FullTurn;
      else if (r < -HalfTurn) r = r + FullTurn;
      return r;
    end
  endfunction
endpackage

// ----- src/hgbs_front.sv -----
// front: takes commands, tracks the load pointer, queues every command in order
`timescale 1ns / 1ps
module hgbs_front #(
  parameter int AddrW = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  logic signed [15:0] cell_value,
  input  logic cell_last,
  input  logic signed [32:0] query_lat,
  input  logic signed [32:0] query_lon,
  input  logic signed [15:0] missing_code,
  input  logic signed [15:0] missing_fill,
  input  logic q_pop,
  output logic q_full,
  output logic q_valid,
  output hgbs_pkg::query_t q_head,
  output logic [AddrW-1:0] q_addr
);
  import hgbs_pkg::*;
  query_t fifo [2];
  logic [AddrW-1:0] fifo_addr [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic [AddrW-1:0] load_address;
  logic grid_loaded;
  logic acc, ld_acc;
  logic signed [15:0] ld_data;

  assign acc = start && !q_full;
  assign ld_acc = acc && !kind;
  assign q_full = cnt == 2'd2;
  assign q_valid = cnt != 2'd0;
  assign q_head = fifo[rp];
  assign q_addr = fifo_addr[rp];
  assign ld_data = (cell_value == missing_code) ? missing_fill : cell_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
      load_address <= '0; grid_loaded <= 1'b0;
    end else begin
      if (acc) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, acc} - {1'b0, q_pop};
      if (ld_acc) begin
        grid_loaded <= cell_last;
        load_address <= cell_last ? '0 : load_address + 1'b1;
      end
    end
  end
  // loads travel with the queries so the grid changes in command order
  always_ff @(posedge clk) begin
    if (acc) begin
      fifo[wp] <= '{is_load: !kind, loaded: grid_loaded, lat: query_lat, lon: query_lon,
                    data: ld_data};
      fifo_addr[wp] <= load_address;
    end
  end
endmodule

// ----- src/hgbs_back.sv -----
// back: grid writes, coordinates, four corner reads and the bilinear blend
`timescale 1ns / 1ps
module hgbs_back #(
  parameter int AddrW = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  hgbs_pkg::query_t q_head,
  input  logic [AddrW-1:0] q_addr,
  output logic q_pop,
  input  logic signed [32:0] origin_lat,
  input  logic signed [32:0] origin_lon,
  input  logic [31:0] lat_scale,
  input  logic [31:0] lon_scale,
  input  logic [11:0] cols,
  input  logic [11:0] rows,
  output logic done,
  output logic signed [23:0] height,
  output logic ready_res
);
  import hgbs_pkg::*;
  typedef enum logic [8:0] {
    S_IDLE = 9'h001, S_MUL = 9'h002, S_POS = 9'h004, S_FRAC = 9'h008,
    S_RD = 9'h010, S_WT = 9'h020, S_ACC = 9'h040, S_RND = 9'h080, S_OUT = 9'h100
  } st_t;
  st_t st;
  logic signed [15:0] mem [2**AddrW];
  logic signed [15:0] rd;
  logic [AddrW-1:0] raddr;
  logic rd_in, rd_in_q;
  logic ld_we;
  logic signed [35:0] dlat, dlon;
  logic slat, slon;
  logic [63:0] plat, plon;
  logic signed [41:0] ypos, xpos;
  logic ny, nx;
  logic signed [25:0] iy, ix;
  logic signed [17:0] fy, fx;
  logic [1:0] corner, acc_c;
  logic signed [34:0] wprod;
  logic signed [34:0] wq;
  logic signed [16:0] vq;
  logic signed [55:0] sum;
  logic signed [55:0] term;
  logic [55:0] mag;
  logic [32:0] qv;
  logic acc_go;

  // corner address
  logic signed [26:0] r, c;
  logic signed [45:0] lin;
  always_comb begin
    r = {iy[25], iy} + {26'd0, corner[1]};
    c = {ix[25], ix} + {26'd0, corner[0]};
    rd_in = r >= 0 && r < $signed({15'd0, rows})
            && c >= 0 && c < $signed({15'd0, cols});
    lin = 46'(r[11:0] * cols) + 46'(c[11:0]);
    raddr = lin[AddrW-1:0];
  end

  assign ld_we = st == S_IDLE && q_valid && q_head.is_load;

  always_ff @(posedge clk) begin
    if (ld_we) mem[q_addr] <= q_head.data;
    rd <= mem[raddr];
  end

  function automatic logic signed [17:0] wsel(input logic b, input logic signed [17:0] f);
    return b ? f : 18'sd65536 - f;
  endfunction

  assign q_pop = st == S_IDLE && q_valid;
  assign term = 56'(wq * vq);
  assign mag = sum[55] ? -sum : sum;
  // negative position with a fraction: truncation toward zero rounds up
  assign ny = ypos[41] && ypos[15:0] != 16'd0;
  assign nx = xpos[41] && xpos[15:0] != 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; done <= 1'b0; acc_go <= 1'b0;
    end else begin
      done <= (st == S_OUT)
              || (st == S_IDLE && q_valid && !q_head.is_load && !q_head.loaded);
      unique case (st)
        S_IDLE: if (q_valid && !q_head.is_load) begin
          if (q_head.loaded) st <= S_MUL;
          else begin
            height <= '0; ready_res <= 1'b0;
          end
          dlat <= wrap_deg(36'(q_head.lat) - 36'(origin_lat));
          dlon <= wrap_deg(36'(q_head.lon) - 36'(origin_lon));
        end
        S_MUL: begin
          slat <= dlat[35]; slon <= dlon[35];
          plat <= 64'(32'(dlat[35] ? -dlat : dlat) * lat_scale);
          plon <= 64'(32'(dlon[35] ? -dlon : dlon) * lon_scale);
          st <= S_POS;
        end
        S_POS: begin
          ypos <= (($signed({30'd0, rows}) - 42'sd1) <<< 16)
                  - (slat ? -$signed({2'b00, plat[63:24]}) : $signed({2'b00, plat[63:24]}));
          xpos <= slon ? -$signed({2'b00, plon[63:24]}) : $signed({2'b00, plon[63:24]});
          st <= S_FRAC;
        end
        S_FRAC: begin
          iy <= ypos[41:16] + {25'd0, ny};
          ix <= xpos[41:16] + {25'd0, nx};
          fy <= ny ? $signed({2'b11, ypos[15:0]}) : $signed({2'b00, ypos[15:0]});
          fx <= nx ? $signed({2'b11, xpos[15:0]}) : $signed({2'b00, xpos[15:0]});
          corner <= 2'd0; sum <= '0; acc_go <= 1'b0;
          st <= S_RD;
        end
        S_RD: begin
          rd_in_q <= rd_in; acc_c <= corner;
          wprod <= 35'(wsel(corner[0], fx) * wsel(corner[1], fy));
          if (acc_go) sum <= sum + term;
          st <= S_WT;
        end
        S_WT: begin
          vq <= (!rd_in_q || rd == 0) ? -17'sd100 : 17'(rd);
          wq <= wprod;
          acc_go <= 1'b1;
          corner <= corner + 2'd1;
          st <= (acc_c == 2'd3) ? S_ACC : S_RD;
        end
        S_ACC: begin
          sum <= sum + term;
          st <= S_RND;
        end
        S_RND: begin
          qv <= 33'((mag + 56'(1 << 23)) >> 24);
          st <= S_OUT;
        end
        S_OUT: begin
          ready_res <= 1'b1;
          if (sum[55]) height <= (qv > 33'd8388608) ? 24'sh800000 : 24'(-qv);
          else height <= (qv > 33'd8388607) ? 24'sh7FFFFF : 24'(qv);
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/height_grid_bilinear_sampler.sv -----
// top level of the height grid sampler
//
// commands enter on start (taken when busy is low); kind 0 loads the next
// grid cell in row-major order, kind 1 queries a position
// every command passes a two-entry queue between front and back, so loads
// and queries reach the grid in the order they were taken
// with the back end idle a load is written in the cycle after it is taken
// and gives no result
// a query gives one result on height/ready_res with done high for one cycle;
// on a loaded grid the back end multiplies, forms the position and fraction,
// reads the four corners one after another from the grid memory, blends,
// rounds and outputs before it takes the next command; a query before the
// grid is loaded answers in the cycle after it reaches the back end, with ready_res low
// busy is high while the queue is full
// config writes on cfg_we/cfg_idx/cfg_data take effect at once; write only when idle
// reset clears the queue, the load pointer and the loaded flag; grid contents
// stay undefined until loaded; the receiver cannot stall
`timescale 1ns / 1ps
module height_grid_bilinear_sampler #(
  parameter int MAX_CELLS = hgbs_pkg::MaxCells
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic kind,
  input  logic signed [15:0] cell_value,
  input  logic cell_last,
  input  logic signed [32:0] query_lat,
  input  logic signed [32:0] query_lon,
  input  logic cfg_we,
  input  logic [hgbs_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [hgbs_pkg::CfgW-1:0] cfg_data,
  output logic done,
  output logic signed [23:0] height,
  output logic ready_res
);
  import hgbs_pkg::*;
  localparam int AddrW = $clog2(MAX_CELLS);
  logic signed [32:0] origin_lat, origin_lon;
  logic [31:0] lat_scale, lon_scale;
  logic [10:0] grid_columns, grid_rows;
  logic signed [15:0] missing_code, missing_fill;
  logic [11:0] cols, rows;
  logic q_pop, q_valid;
  query_t q_head;
  logic [AddrW-1:0] q_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_lat <= '0; origin_lon <= '0; lat_scale <= '0; lon_scale <= '0;
      grid_columns <= 11'd1; grid_rows <= 11'd1;
      missing_code <= '0; missing_fill <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_ORIGIN_LAT: origin_lat <= cfg_data;
        REG_ORIGIN_LON: origin_lon <= cfg_data;
        REG_LAT_SCALE: lat_scale <= cfg_data[31:0];
        REG_LON_SCALE: lon_scale <= cfg_data[31:0];
        REG_COLUMNS: grid_columns <= cfg_data[10:0];
        REG_ROWS: grid_rows <= cfg_data[10:0];
        REG_MISS_CODE: missing_code <= cfg_data[15:0];
        REG_MISS_FILL: missing_fill <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
  assign cols = (grid_columns > 11'(MaxSide)) ? 12'(MaxSide) : {1'b0, grid_columns};
  assign rows = (grid_rows > 11'(MaxSide)) ? 12'(MaxSide) : {1'b0, grid_rows};

  hgbs_front #(.AddrW(AddrW)) u_front (
    .clk, .rst, .start, .kind, .cell_value, .cell_last, .query_lat, .query_lon,
    .missing_code, .missing_fill, .q_pop, .q_full(busy), .q_valid, .q_head, .q_addr
  );
  hgbs_back #(.AddrW(AddrW)) u_back (
    .clk, .rst, .q_valid, .q_head, .q_addr, .q_pop,
    .origin_lat, .origin_lon, .lat_scale, .lon_scale, .cols, .rows,
    .done, .height, .ready_res
  );
endmodule

// ----- src/hgbs_checker.sv -----
// port checker for the height grid sampler, bound to the top level
`timescale 1ns / 1ps
module hgbs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [23:0] height,
  input logic ready_res
);
  a_rst_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("activity right after reset");
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ready_res) |-> height == 24'sd0)
    else $error("not-ready result with nonzero height");
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({height, ready_res}))
    else $error("result with unknown bits");
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a command");
endmodule

bind height_grid_bilinear_sampler hgbs_checker u_chk (
  .clk, .rst, .start, .busy, .done, .height, .ready_res
);
